/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the segment intersection block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/segx_pkg.sv */
// ----------------------------------------------------------------------------
// Segment intersection package
// Constants and result codes shared by the intersection datapath modules.
// ----------------------------------------------------------------------------
package segx_pkg;

  // Default coordinate width (Q16.16 signed).
  localparam int COORD_WIDTH_DEF = 32;

  // Fraction bits of the segment parameters t and u (Q1.30).
  localparam int PARAM_FRAC = 30;

  // Quotient bits: one integer bit plus the fraction.
  localparam int QUOT_W = PARAM_FRAC + 1;

  // Result codes.
  localparam logic [1:0] OUTC_INTERSECT = 2'd0;
  localparam logic [1:0] OUTC_PARALLEL  = 2'd1;
  localparam logic [1:0] OUTC_OUTSIDE   = 2'd2;

  // Configuration register indexes.
  localparam logic [7:0] CFG_PARALLEL_LIMIT = 8'd0;
  localparam logic [7:0] CFG_PARAM_TOL      = 8'd1;

endpackage

/* src/segx_divider.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces a Q1.30 quotient of two magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module segx_divider
  import segx_pkg::*;
#(
  parameter int NUM_WIDTH = 2 * COORD_WIDTH_DEF + 3
) (
  input  logic                 clk,
  input  logic [NUM_WIDTH-1:0] in_num,
  input  logic [NUM_WIDTH-1:0] in_den,
  output logic [QUOT_W-1:0]    out_quot
);

  localparam int RW = NUM_WIDTH + 1;

  logic [RW-1:0]        rem_r [QUOT_W];
  logic [NUM_WIDTH-1:0] den_r [QUOT_W];
  logic [QUOT_W-1:0]    quot_r [QUOT_W];

  genvar k;
  generate
    for (k = 0; k < QUOT_W; k++) begin : g_stage
      logic [RW-1:0]        trial;
      logic [RW-1:0]        rem_nxt;
      logic [NUM_WIDTH-1:0] den_in;
      logic [QUOT_W-1:0]    quot_in;
      logic                 ge;

      // The first stage tests the integer bit; later stages shift first.
      if (k == 0) begin : g_first
        assign trial   = {1'b0, in_num};
        assign den_in  = in_den;
        assign quot_in = '0;
      end else begin : g_next
        assign trial   = {rem_r[k-1][RW-2:0], 1'b0};
        assign den_in  = den_r[k-1];
        assign quot_in = quot_r[k-1];
      end

      assign ge      = (trial >= {1'b0, den_in});
      assign rem_nxt = ge ? (trial - {1'b0, den_in}) : trial;

      always_ff @(posedge clk) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_in;
        quot_r[k] <= {quot_in[QUOT_W-2:0], ge};
      end
    end
  endgenerate

  assign out_quot = quot_r[QUOT_W-1];

endmodule

/* src/segment_intersection_2d_top.sv */
// ----------------------------------------------------------------------------
// Segment intersection, 2D
// Fully pipelined intersection of two Q16.16 segments with parallel and
// outside-segment detection and a saturated intersection point.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  input    start, busy            eight segment endpoint coordinates
//  result   out_valid (strobe)     out_outcome, out_cross_x, out_cross_y
//  config   cfg_valid, cfg_ready   cfg_index, cfg_data
//
// One transaction enters per cycle; busy stays low and cfg_ready stays high.
// A transaction passes 5 + 31 + 3 = 39 register stages, the 31-stage quotient
// pipeline sitting between the cross product and point stages.
// Reset clears the valid pipeline and loads the register defaults.
// The receiver cannot stall, so no stage ever holds.
// ----------------------------------------------------------------------------
module segment_intersection_2d_top
  import segx_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_first_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_first_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_end_y,
  output logic                          out_valid,
  output logic [1:0]                    out_outcome,
  output logic signed [COORD_WIDTH-1:0] out_cross_x,
  output logic signed [COORD_WIDTH-1:0] out_cross_y,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [7:0]                    cfg_index,
  input  logic [63:0]                   cfg_data
);

`include "assert_macros.svh"

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int PRW = 2 * CW + 2;
  localparam int SW  = 2 * CW + 3;
  localparam int PW  = DW + QUOT_W;
  localparam int QW  = PW - PARAM_FRAC;
  localparam int EW  = CW + 4;
  localparam int LAT = 5 + QUOT_W + 3;

  typedef struct packed {
    logic [1:0]           outcome;
    logic                 t_neg;
    logic                 u_neg;
    logic signed [CW-1:0] a0x;
    logic signed [CW-1:0] a0y;
    logic signed [DW-1:0] rx;
    logic signed [DW-1:0] ry;
  } side_t;

  // Configuration registers.
  logic [62:0] limit_r;
  logic [29:0] tol_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 63'd4295;
      tol_r   <= 30'd107374;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PARALLEL_LIMIT) begin
        limit_r <= cfg_data[62:0];
      end else if (cfg_index == CFG_PARAM_TOL) begin
        tol_r <= cfg_data[29:0];
      end
    end
  end

  // Valid bits travel along the whole pipeline.
  logic             accept;
  logic [LAT-1:0]   v_r;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[LAT-2:0], accept};
    end
  end

  // Stage 1: direction and offset vectors.
  logic signed [CW-1:0] s1_a0x_r, s1_a0y_r;
  logic signed [DW-1:0] s1_rx_r, s1_ry_r, s1_sx_r, s1_sy_r, s1_qx_r, s1_qy_r;

  always_ff @(posedge clk) begin
    s1_a0x_r <= in_first_start_x;
    s1_a0y_r <= in_first_start_y;
    s1_rx_r  <= DW'(in_first_end_x)    - DW'(in_first_start_x);
    s1_ry_r  <= DW'(in_first_end_y)    - DW'(in_first_start_y);
    s1_sx_r  <= DW'(in_second_end_x)   - DW'(in_second_start_x);
    s1_sy_r  <= DW'(in_second_end_y)   - DW'(in_second_start_y);
    s1_qx_r  <= DW'(in_second_start_x) - DW'(in_first_start_x);
    s1_qy_r  <= DW'(in_second_start_y) - DW'(in_first_start_y);
  end

  // Stage 2: the six partial products of the three cross products.
  logic signed [PRW-1:0] s2_d1_r, s2_d2_r, s2_t1_r, s2_t2_r, s2_u1_r, s2_u2_r;
  logic signed [CW-1:0]  s2_a0x_r, s2_a0y_r;
  logic signed [DW-1:0]  s2_rx_r, s2_ry_r;

  always_ff @(posedge clk) begin
    s2_d1_r  <= PRW'(s1_rx_r) * PRW'(s1_sy_r);
    s2_d2_r  <= PRW'(s1_ry_r) * PRW'(s1_sx_r);
    s2_t1_r  <= PRW'(s1_qx_r) * PRW'(s1_sy_r);
    s2_t2_r  <= PRW'(s1_qy_r) * PRW'(s1_sx_r);
    s2_u1_r  <= PRW'(s1_qx_r) * PRW'(s1_ry_r);
    s2_u2_r  <= PRW'(s1_qy_r) * PRW'(s1_rx_r);
    s2_a0x_r <= s1_a0x_r;
    s2_a0y_r <= s1_a0y_r;
    s2_rx_r  <= s1_rx_r;
    s2_ry_r  <= s1_ry_r;
  end

  // Stage 3: cross products.
  logic signed [SW-1:0] s3_den_r, s3_tn_r, s3_un_r;
  logic signed [CW-1:0] s3_a0x_r, s3_a0y_r;
  logic signed [DW-1:0] s3_rx_r, s3_ry_r;

  always_ff @(posedge clk) begin
    s3_den_r <= SW'(s2_d1_r) - SW'(s2_d2_r);
    s3_tn_r  <= SW'(s2_t1_r) - SW'(s2_t2_r);
    s3_un_r  <= SW'(s2_u1_r) - SW'(s2_u2_r);
    s3_a0x_r <= s2_a0x_r;
    s3_a0y_r <= s2_a0y_r;
    s3_rx_r  <= s2_rx_r;
    s3_ry_r  <= s2_ry_r;
  end

  // Stage 4: sign and magnitude, parallel test.
  logic [SW-1:0]        den_mag_nxt, tn_mag_nxt, un_mag_nxt;
  logic                 par_nxt;
  logic [SW-1:0]        s4_den_r, s4_tn_r, s4_un_r;
  logic                 s4_dneg_r, s4_tneg_r, s4_uneg_r, s4_par_r;
  logic signed [CW-1:0] s4_a0x_r, s4_a0y_r;
  logic signed [DW-1:0] s4_rx_r, s4_ry_r;

  assign den_mag_nxt = s3_den_r[SW-1] ? SW'(-s3_den_r) : SW'(s3_den_r);
  assign tn_mag_nxt  = s3_tn_r[SW-1]  ? SW'(-s3_tn_r)  : SW'(s3_tn_r);
  assign un_mag_nxt  = s3_un_r[SW-1]  ? SW'(-s3_un_r)  : SW'(s3_un_r);
  assign par_nxt     = {{64{1'b0}}, den_mag_nxt} <= {{(SW + 1){1'b0}}, limit_r};

  always_ff @(posedge clk) begin
    s4_den_r  <= den_mag_nxt;
    s4_tn_r   <= tn_mag_nxt;
    s4_un_r   <= un_mag_nxt;
    s4_dneg_r <= s3_den_r[SW-1];
    s4_tneg_r <= s3_tn_r[SW-1];
    s4_uneg_r <= s3_un_r[SW-1];
    s4_par_r  <= par_nxt;
    s4_a0x_r  <= s3_a0x_r;
    s4_a0y_r  <= s3_a0y_r;
    s4_rx_r   <= s3_rx_r;
    s4_ry_r   <= s3_ry_r;
  end

  // Stage 5: a ratio of two or more is always outside the segments.
  logic       big_nxt;
  logic [1:0] early_nxt;
  logic [SW-1:0] s5_den_r, s5_tn_r, s5_un_r;
  side_t      s5_side_r;

  assign big_nxt = ({1'b0, s4_tn_r} >= {s4_den_r, 1'b0}) ||
                   ({1'b0, s4_un_r} >= {s4_den_r, 1'b0});

  always_comb begin
    if (s4_par_r) begin
      early_nxt = OUTC_PARALLEL;
    end else if (big_nxt) begin
      early_nxt = OUTC_OUTSIDE;
    end else begin
      early_nxt = OUTC_INTERSECT;
    end
  end

  always_ff @(posedge clk) begin
    s5_den_r          <= s4_den_r;
    s5_tn_r           <= s4_tn_r;
    s5_un_r           <= s4_un_r;
    s5_side_r.outcome <= early_nxt;
    s5_side_r.t_neg   <= s4_tneg_r ^ s4_dneg_r;
    s5_side_r.u_neg   <= s4_uneg_r ^ s4_dneg_r;
    s5_side_r.a0x     <= s4_a0x_r;
    s5_side_r.a0y     <= s4_a0y_r;
    s5_side_r.rx      <= s4_rx_r;
    s5_side_r.ry      <= s4_ry_r;
  end

  // Quotient pipelines for t and u, with the sideband kept in step.
  logic [QUOT_W-1:0] t_quot, u_quot;
  side_t             dside_r [QUOT_W];

  segx_divider #(.NUM_WIDTH(SW)) u_div_t (
    .clk      (clk),
    .in_num   (s5_tn_r),
    .in_den   (s5_den_r),
    .out_quot (t_quot)
  );

  segx_divider #(.NUM_WIDTH(SW)) u_div_u (
    .clk      (clk),
    .in_num   (s5_un_r),
    .in_den   (s5_den_r),
    .out_quot (u_quot)
  );

  always_ff @(posedge clk) begin
    dside_r[0] <= s5_side_r;
    for (int i = 1; i < QUOT_W; i++) begin
      dside_r[i] <= dside_r[i-1];
    end
  end

  // Stage 6: signed parameters and range test.
  side_t              dlast;
  logic signed [32:0] t_nxt, u_nxt, lo_bound, hi_bound;
  logic               in_rng_nxt;
  logic [1:0]         s6_outcome_r;
  logic signed [32:0] s6_t_r;
  logic signed [CW-1:0] s6_a0x_r, s6_a0y_r;
  logic signed [DW-1:0] s6_rx_r, s6_ry_r;

  assign dlast      = dside_r[QUOT_W-1];
  assign t_nxt      = dlast.t_neg ? -$signed({2'b0, t_quot}) : $signed({2'b0, t_quot});
  assign u_nxt      = dlast.u_neg ? -$signed({2'b0, u_quot}) : $signed({2'b0, u_quot});
  assign lo_bound   = -$signed({3'b0, tol_r});
  assign hi_bound   = $signed(33'd1 << PARAM_FRAC) + $signed({3'b0, tol_r});
  assign in_rng_nxt = (t_nxt >= lo_bound) && (t_nxt <= hi_bound) &&
                      (u_nxt >= lo_bound) && (u_nxt <= hi_bound);

  always_ff @(posedge clk) begin
    if (dlast.outcome == OUTC_INTERSECT && !in_rng_nxt) begin
      s6_outcome_r <= OUTC_OUTSIDE;
    end else begin
      s6_outcome_r <= dlast.outcome;
    end
    s6_t_r   <= t_nxt;
    s6_a0x_r <= dlast.a0x;
    s6_a0y_r <= dlast.a0y;
    s6_rx_r  <= dlast.rx;
    s6_ry_r  <= dlast.ry;
  end

  // Stage 7: magnitude of r times t.
  logic [QUOT_W-1:0] tmag_nxt;
  logic [DW-1:0]     rxmag_nxt, rymag_nxt;
  logic [PW-1:0]     s7_mx_r, s7_my_r;
  logic              s7_negx_r, s7_negy_r;
  logic [1:0]        s7_outcome_r;
  logic signed [CW-1:0] s7_a0x_r, s7_a0y_r;

  assign tmag_nxt  = s6_t_r[32] ? QUOT_W'(-s6_t_r) : QUOT_W'(s6_t_r);
  assign rxmag_nxt = s6_rx_r[DW-1] ? DW'(-s6_rx_r) : DW'(s6_rx_r);
  assign rymag_nxt = s6_ry_r[DW-1] ? DW'(-s6_ry_r) : DW'(s6_ry_r);

  always_ff @(posedge clk) begin
    s7_mx_r      <= PW'(rxmag_nxt) * PW'(tmag_nxt);
    s7_my_r      <= PW'(rymag_nxt) * PW'(tmag_nxt);
    s7_negx_r    <= s6_rx_r[DW-1] ^ s6_t_r[32];
    s7_negy_r    <= s6_ry_r[DW-1] ^ s6_t_r[32];
    s7_outcome_r <= s6_outcome_r;
    s7_a0x_r     <= s6_a0x_r;
    s7_a0y_r     <= s6_a0y_r;
  end

  // Stage 8: floor shift, add the start point and saturate.
  localparam logic signed [EW-1:0] SAT_HI = EW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

  function automatic logic signed [CW-1:0] place(
    input logic signed [CW-1:0] base,
    input logic [PW-1:0]        mag,
    input logic                 neg
  );
    logic signed [EW-1:0] step;
    logic signed [EW-1:0] sum;
    logic [QW-1:0]        whole;
    logic                 frac_nz;
    whole   = mag[PW-1:PARAM_FRAC];
    frac_nz = |mag[PARAM_FRAC-1:0];
    if (neg) begin
      step = -($signed(EW'(whole)) + $signed(EW'(frac_nz)));
    end else begin
      step = $signed(EW'(whole));
    end
    sum = EW'(base) + step;
    if (sum > SAT_HI) begin
      sum = SAT_HI;
    end else if (sum < SAT_LO) begin
      sum = SAT_LO;
    end
    return sum[CW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    out_outcome <= s7_outcome_r;
    if (s7_outcome_r == OUTC_INTERSECT) begin
      out_cross_x <= place(s7_a0x_r, s7_mx_r, s7_negx_r);
      out_cross_y <= place(s7_a0y_r, s7_my_r, s7_negy_r);
    end else begin
      out_cross_x <= '0;
      out_cross_y <= '0;
    end
  end

  assign out_valid = v_r[LAT-1];

  // Checks on the pipeline timing and result encoding.
  `ASSERT_CLK(a_latency, accept |-> ##LAT out_valid, "result missing after fixed latency")
  `ASSERT_CLK(a_no_spurious, out_valid |-> $past(accept, LAT), "result without a transaction")
  `ASSERT_CLK(a_zero_point, out_valid && out_outcome != OUTC_INTERSECT |-> out_cross_x == '0 && out_cross_y == '0, "nonzero point without intersection")
  `ASSERT_NEVER(a_never_busy, busy, "busy raised on a pipeline that never holds")

endmodule

/* tb/sv/segment_intersection_2d_top_tb.sv */
// ----------------------------------------------------------------------------
// Segment intersection regression
// Drives segment pairs through the block under several register settings and
// idle patterns, predicts each outcome and point with exact wide arithmetic,
// and compares every result strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
module segment_intersection_2d_top_tb
  import segx_pkg::*;
;

  localparam int CW = 32;
  localparam int PIPE_DEPTH = 39;

  typedef struct packed {
    logic [1:0]           outcome;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } seg_result_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [CW-1:0] in_a0x, in_a0y, in_a1x, in_a1y;
  logic signed [CW-1:0] in_b0x, in_b0y, in_b1x, in_b1y;
  logic out_valid;
  logic [1:0] out_outcome;
  logic signed [CW-1:0] out_cross_x, out_cross_y;
  logic cfg_valid;
  logic cfg_ready;
  logic [7:0] cfg_index;
  logic [63:0] cfg_data;

  // Local copy of the registers used by the predictor.
  logic [62:0] limit_reg;
  logic [29:0] tol_reg;

  seg_result_t pending_results[$];
  int error_count;
  int send_idle_pct;

  segment_intersection_2d_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_start_x(in_a0x), .in_first_start_y(in_a0y),
    .in_first_end_x(in_a1x), .in_first_end_y(in_a1y),
    .in_second_start_x(in_b0x), .in_second_start_y(in_b0y),
    .in_second_end_x(in_b1x), .in_second_end_y(in_b1y),
    .out_valid(out_valid), .out_outcome(out_outcome),
    .out_cross_x(out_cross_x), .out_cross_y(out_cross_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("segment_intersection_2d_top regression: fail");
    $finish;
  end

  // Truncated Q2.30 quotient; returns 0 when the ratio reaches two.
  function automatic bit param_ratio(input logic signed [127:0] num,
                                     input logic signed [127:0] den,
                                     output logic signed [63:0] ratio);
    logic [127:0] nm, dm, q;
    nm = num[127] ? -num : num;
    dm = den[127] ? -den : den;
    ratio = 0;
    if (nm >= (dm << 1)) return 0;
    q = (nm << PARAM_FRAC) / dm;
    ratio = (num[127] != den[127]) ? -$signed({1'b0, q[62:0]}) : $signed({1'b0, q[62:0]});
    return 1;
  endfunction

  // Parameter inside the tolerance window.
  function automatic bit param_ok(input logic signed [63:0] t);
    logic signed [63:0] tol;
    tol = $signed({34'd0, tol_reg});
    return (t >= -tol) && (t <= (64'sd1 <<< PARAM_FRAC) + tol);
  endfunction

  // One coordinate of A0 + r*t with floor rounding and saturation.
  function automatic logic signed [CW-1:0] point_coord(input logic signed [63:0] base,
                                                       input logic signed [63:0] dir,
                                                       input logic signed [63:0] t);
    logic signed [127:0] prod, v;
    prod = 128'(dir) * 128'(t);
    v = 128'(base) + (prod >>> PARAM_FRAC);
    if (v > 128'sd2147483647) v = 128'sd2147483647;
    if (v < -128'sd2147483648) v = -128'sd2147483648;
    return v[CW-1:0];
  endfunction

  // Predicts the result of one segment pair.
  function automatic seg_result_t predict_intersection(input logic signed [CW-1:0] c[8]);
    seg_result_t res;
    logic signed [63:0] rx, ry, sx, sy, qx, qy, t, u;
    logic signed [127:0] den, tn, un, dmag;
    res = '0;
    rx = 64'(c[2]) - 64'(c[0]);
    ry = 64'(c[3]) - 64'(c[1]);
    sx = 64'(c[6]) - 64'(c[4]);
    sy = 64'(c[7]) - 64'(c[5]);
    qx = 64'(c[4]) - 64'(c[0]);
    qy = 64'(c[5]) - 64'(c[1]);
    den = 128'(rx) * 128'(sy) - 128'(ry) * 128'(sx);
    tn = 128'(qx) * 128'(sy) - 128'(qy) * 128'(sx);
    un = 128'(qx) * 128'(ry) - 128'(qy) * 128'(rx);
    dmag = den[127] ? -den : den;
    if (dmag <= 128'(limit_reg)) begin
      res.outcome = OUTC_PARALLEL;
    end else if (!param_ratio(tn, den, t) || !param_ratio(un, den, u) ||
                 !param_ok(t) || !param_ok(u)) begin
      res.outcome = OUTC_OUTSIDE;
    end else begin
      res.outcome = OUTC_INTERSECT;
      res.px = point_coord(64'(c[0]), rx, t);
      res.py = point_coord(64'(c[1]), ry, t);
    end
    return res;
  endfunction

  // Result checker: every strobe is matched against the oldest prediction.
  always @(posedge clk) begin
    seg_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: outcome %0d", out_outcome);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_outcome !== exp_res.outcome) begin
          $error("outcome: expected %0d, actual %0d", exp_res.outcome, out_outcome);
          error_count++;
        end
        if (out_cross_x !== exp_res.px) begin
          $error("cross_x: expected %0d, actual %0d", exp_res.px, out_cross_x);
          error_count++;
        end
        if (out_cross_y !== exp_res.py) begin
          $error("cross_y: expected %0d, actual %0d", exp_res.py, out_cross_y);
          error_count++;
        end
      end
    end
  end

  // Sends one segment pair, with an optional random idle gap first.
  // Start stays high afterwards so the next pair can follow without a gap;
  // drain_pipeline releases it.
  task automatic send_segments(input logic signed [CW-1:0] c[8]);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    {in_a0x, in_a0y, in_a1x, in_a1y} <= {c[0], c[1], c[2], c[3]};
    {in_b0x, in_b0y, in_b1x, in_b1y} <= {c[4], c[5], c[6], c[7]};
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results = {pending_results, predict_intersection(c)};
  endtask

  // Waits for the pipeline to drain.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // Writes one register; only called while the block is idle.
  task automatic write_register(input logic [7:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_PARALLEL_LIMIT) limit_reg = value[62:0];
    else if (idx == CFG_PARAM_TOL) tol_reg = value[29:0];
    @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(input int span);
    if (span == 0) return $signed($urandom);
    return $signed(CW'($urandom_range(2 * span)) - CW'(span));
  endfunction

  // Random pair: mostly pairs of modest size, some crossing or parallel by construction, plus wide noise.
  task automatic send_random_pair();
    logic signed [CW-1:0] c[8];
    int sel, span;
    sel = $urandom_range(9);
    span = (sel < 6) ? 32'h0004_0000 : (sel < 8) ? 32'h2000_0000 : 0;
    foreach (c[i]) c[i] = rand_coord(span);
    if (sel == 2) begin
      // Crossing by construction: B straddles A around its midpoint.
      c[4] = c[0] + rand_coord(32'h0000_8000) - (c[3] - c[1]);
      c[5] = c[1] + rand_coord(32'h0000_8000) + (c[2] - c[0]);
      c[6] = c[2] + (c[3] - c[1]);
      c[7] = c[3] - (c[2] - c[0]);
    end else if (sel == 3) begin
      // Parallel copy of A.
      c[6] = c[4] + (c[2] - c[0]);
      c[7] = c[5] + (c[3] - c[1]);
    end
    send_segments(c);
  endtask

  // Directed corners: extremes, degenerate, parallel, outside, saturation.
  task automatic test_directed();
    logic signed [CW-1:0] c[8];
    logic signed [CW-1:0] mx, mn;
    mx = 32'sh7fff_ffff;
    mn = -32'sh8000_0000;
    c = '{0, 0, 32'h20000, 32'h20000, 0, 32'h20000, 32'h20000, 0};
    send_segments(c);
    c = '{0, 0, 32'h10000, 32'h10000, 32'h20000, 0, 32'h20000, 32'h20000};
    send_segments(c);
    c = '{5, 5, 5, 5, 0, 0, 32'h10000, 32'h10000};
    send_segments(c);
    c = '{0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000};
    send_segments(c);
    c = '{0, 0, 32'h10000, 32'h10000, 32'h50000, 0, 32'h50000, 32'h10000};
    send_segments(c);
    c = '{0, 0, 32'h10000, 0, 32'h10000, -32'sh10000, 32'h10000, 32'h10000};
    send_segments(c);
    c = '{mn, mn, mx, mx, mn, mx, mx, mn};
    send_segments(c);
    c = '{mx, mn, mn, mx, mn, mn, mx, mx};
    send_segments(c);
    c = '{mx, mx, mn, mn, mx, mn, mn, mx};
    send_segments(c);
    c = '{mn, 0, mx, 0, 0, mn, 0, mx};
    send_segments(c);
    c = '{mn, mn, mn, mn, mx, mx, mx, mx};
    send_segments(c);
    c = '{-1, -1, 1, 1, -1, 1, 1, -1};
    send_segments(c);
    c = '{0, 0, 3, 1, 0, 1, 3, 0};
    send_segments(c);
    c = '{0, 0, 32'h10000, 0, 32'h10001, -32'sh100, 32'h10001, 32'h100};
    send_segments(c);
    c = '{0, 0, 32'h10000, 0, 32'h3fff, 1, 32'h3fff, 32'h10001};
    send_segments(c);
  endtask

  // Register settings: extremes of both registers, a mixed setting, a write to an unused index and the defaults.
  task automatic test_registers();
    int k;
    write_register(CFG_PARALLEL_LIMIT, 64'd0);
    write_register(CFG_PARAM_TOL, 64'd0);
    for (k = 0; k < 40; k++) send_random_pair();
    drain_pipeline();
    write_register(CFG_PARALLEL_LIMIT, 64'hffff_ffff_ffff_ffff);
    write_register(CFG_PARAM_TOL, 64'hffff_ffff_ffff_ffff);
    for (k = 0; k < 30; k++) send_random_pair();
    drain_pipeline();
    write_register(CFG_PARALLEL_LIMIT, 64'h0000_0001_0000_0000);
    write_register(CFG_PARAM_TOL, 64'h3fff_ffff);
    for (k = 0; k < 40; k++) send_random_pair();
    drain_pipeline();
    write_register(8'd7, 64'd123);
    write_register(CFG_PARALLEL_LIMIT, 64'd4295);
    write_register(CFG_PARAM_TOL, 64'd107374);
    drain_pipeline();
  endtask

  // Random pairs under each sender idle pattern.
  task automatic test_random_traffic();
    int phase, k;
    int idle_pct[4] = '{0, 87, 0, 17};
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_pct[phase];
      for (k = 0; k < 130; k++) send_random_pair();
      send_idle_pct = 0;
    end
  endtask

  initial begin
    error_count = 0;
    send_idle_pct = 0;
    limit_reg = 63'd4295;
    tol_reg = 30'd107374;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    {in_a0x, in_a0y, in_a1x, in_a1y, in_b0x, in_b0y, in_b1x, in_b1y} = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain_pipeline();
    test_registers();
    test_random_traffic();
    drain_pipeline();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("segment_intersection_2d_top regression: pass");
    end else begin
      $display("segment_intersection_2d_top regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/segx_pkg.sv
src/segx_divider.sv
src/segment_intersection_2d_top.sv
tb/sv/segment_intersection_2d_top_tb.sv
